### rtl/ipdc_pkg.sv
package ipdc_pkg;

  // field widths
  localparam int CMD_W   = 8;
  localparam int LED_W   = 3;
  localparam int CFG_W   = 20;
  localparam int INDEX_W = 7;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ZERO_MIN   = 3'd0;
  localparam logic [2:0] REG_ZERO_MAX   = 3'd1;
  localparam logic [2:0] REG_TIMEOUT    = 3'd2;
  localparam logic [2:0] REG_FIRST_CMD  = 3'd3;
  localparam logic [2:0] REG_RED_CODE   = 3'd4;
  localparam logic [2:0] REG_GREEN_CODE = 3'd5;
  localparam logic [2:0] REG_BLUE_CODE  = 3'd6;
  localparam logic [2:0] REG_OFF_CODE   = 3'd7;

  // register reset values
  localparam logic [CFG_W-1:0]   ZERO_MIN_RST   = 20'd1000;
  localparam logic [CFG_W-1:0]   ZERO_MAX_RST   = 20'd1500;
  localparam logic [CFG_W-1:0]   TIMEOUT_RST    = 20'd1000000;
  localparam logic [INDEX_W-1:0] FIRST_CMD_RST  = 7'd17;
  localparam logic [CMD_W-1:0]   RED_CODE_RST   = 8'd12;
  localparam logic [CMD_W-1:0]   GREEN_CODE_RST = 8'd24;
  localparam logic [CMD_W-1:0]   BLUE_CODE_RST  = 8'd94;
  localparam logic [CMD_W-1:0]   OFF_CODE_RST   = 8'd69;

  // led level bit positions
  localparam int LED_RED   = 0;
  localparam int LED_GREEN = 1;
  localparam int LED_BLUE  = 2;

  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

endpackage

### rtl/ipdc_tick_if.sv
interface ipdc_tick_if;
  logic valid;
  logic ready;
  logic falling_edge;

  modport source (output valid, output falling_edge, input ready);
  modport sink (input valid, input falling_edge, output ready);
endinterface

### rtl/ipdc_result_if.sv
interface ipdc_result_if
  import ipdc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             led_red;
  logic             led_green;
  logic             led_blue;
  logic [CMD_W-1:0] command_byte;
  logic             frame_done;

  modport source (output valid, output led_red, output led_green, output led_blue,
                  output command_byte, output frame_done, input ready);
  modport sink (input valid, input led_red, input led_green, input led_blue,
                input command_byte, input frame_done, output ready);
endinterface

### rtl/ir_pulse_distance_command_decoder_unit.sv
// channel   | dir | payload                                          | request
// ----------+-----+--------------------------------------------------+-------------------
// tick      | in  | falling_edge                                     | one microsecond tick
// result    | out | led_red, led_green, led_blue, command_byte,      | one per tick
//           |     | frame_done                                       |
// apb       | in  | 8 registers at byte address 4*i, 32-bit data     | config write/read
//
// one tick per cycle while results are taken: a tick is caught in the input register, and the
// decode state and result register update together when that tick moves on.
// a result turns valid once its tick has moved from the input register into the result register.
// rst is synchronous: frame state, registers and both stage valids clear.
// a stalled result holds in the output register while one more tick waits in
// the input register; ticks stop being taken only when both are full.
module ir_pulse_distance_command_decoder_unit
  import ipdc_pkg::*;
#(
  parameter int TICK_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  ipdc_tick_if.sink         tick,
  ipdc_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;
  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [LED_W-1:0] led;
    logic [CMD_W-1:0] cmd;
    logic             done;
  } res_t;

  // configuration registers
  logic [CFG_W-1:0]   zero_min;
  logic [CFG_W-1:0]   zero_max;
  logic [CFG_W-1:0]   timeout;
  logic [INDEX_W-1:0] first_cmd;
  logic [CMD_W-1:0]   red_code;
  logic [CMD_W-1:0]   green_code;
  logic [CMD_W-1:0]   blue_code;
  logic [CMD_W-1:0]   off_code;

  // decode state
  logic                 armed;
  logic [TICK_BITS-1:0] tick_count;
  logic [INDEX_W-1:0]   interval_index;
  logic [CMD_W-1:0]     command_bits;
  logic [CMD_W-1:0]     decoded_byte;
  logic [LED_W-1:0]     led_levels;

  logic                 armed_next;
  logic [TICK_BITS-1:0] tick_count_next;
  logic [INDEX_W-1:0]   interval_index_next;
  logic [CMD_W-1:0]     command_bits_next;
  logic [CMD_W-1:0]     decoded_byte_next;
  logic [LED_W-1:0]     led_levels_next;
  logic                 done_next;

  // pipeline stages
  logic stg_valid;
  logic stg_edge;
  logic res_valid;
  res_t res;
  logic move;

  logic                 cfg_write;
  logic [TICK_BITS-1:0] elapsed;
  logic [CMP_W-1:0]     elapsed_cmp;
  logic                 timeout_hit;
  logic                 in_window;
  logic [INDEX_W-1:0]   rel_index;
  logic                 bit_hit;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_min   <= ZERO_MIN_RST;
      zero_max   <= ZERO_MAX_RST;
      timeout    <= TIMEOUT_RST;
      first_cmd  <= FIRST_CMD_RST;
      red_code   <= RED_CODE_RST;
      green_code <= GREEN_CODE_RST;
      blue_code  <= BLUE_CODE_RST;
      off_code   <= OFF_CODE_RST;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_ZERO_MIN:   zero_min   <= pwdata[CFG_W-1:0];
        REG_ZERO_MAX:   zero_max   <= pwdata[CFG_W-1:0];
        REG_TIMEOUT:    timeout    <= pwdata[CFG_W-1:0];
        REG_FIRST_CMD:  first_cmd  <= pwdata[INDEX_W-1:0];
        REG_RED_CODE:   red_code   <= pwdata[CMD_W-1:0];
        REG_GREEN_CODE: green_code <= pwdata[CMD_W-1:0];
        REG_BLUE_CODE:  blue_code  <= pwdata[CMD_W-1:0];
        REG_OFF_CODE:   off_code   <= pwdata[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      REG_ZERO_MIN:   prdata = APB_DW'(zero_min);
      REG_ZERO_MAX:   prdata = APB_DW'(zero_max);
      REG_TIMEOUT:    prdata = APB_DW'(timeout);
      REG_FIRST_CMD:  prdata = APB_DW'(first_cmd);
      REG_RED_CODE:   prdata = APB_DW'(red_code);
      REG_GREEN_CODE: prdata = APB_DW'(green_code);
      REG_BLUE_CODE:  prdata = APB_DW'(blue_code);
      REG_OFF_CODE:   prdata = APB_DW'(off_code);
      default:        prdata = '0;
    endcase
  end

  // handshake between stages
  assign move       = stg_valid && (!res_valid || result.ready);
  assign tick.ready = !stg_valid || move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      stg_valid <= 1'b1;
    end else if (move) begin
      stg_valid <= 1'b0;
    end
    if (tick.valid && tick.ready) begin
      stg_edge <= tick.falling_edge;
    end
  end

  // saturating interval count and window compares
  assign elapsed     = (tick_count == TICK_MAX) ? tick_count : tick_count + 1'b1;
  assign elapsed_cmp = CMP_W'(elapsed);
  assign timeout_hit = elapsed_cmp >= CMP_W'(timeout);
  assign in_window   = (elapsed_cmp >= CMP_W'(zero_min)) && (elapsed_cmp <= CMP_W'(zero_max));
  assign rel_index   = interval_index - first_cmd;
  assign bit_hit     = (interval_index >= first_cmd) && (rel_index[INDEX_W-1:3] == '0);

  // next decode state for the tick in the input register
  always_comb begin
    armed_next          = armed;
    tick_count_next     = tick_count;
    interval_index_next = interval_index;
    command_bits_next   = command_bits;
    decoded_byte_next   = decoded_byte;
    led_levels_next     = led_levels;
    done_next           = 1'b0;
    if (!armed) begin
      if (stg_edge) begin
        armed_next      = 1'b1;
        tick_count_next = '0;
      end
    end else if (stg_edge) begin
      // edge records a command bit when its index falls in the command span
      if (bit_hit) begin
        command_bits_next[rel_index[2:0]] = !in_window;
      end
      if (interval_index != INDEX_MAX) begin
        interval_index_next = interval_index + 1'b1;
      end
      tick_count_next = '0;
    end else if (timeout_hit) begin
      // frame end: latch byte and apply the first matching code
      decoded_byte_next = command_bits;
      if (command_bits == red_code) begin
        led_levels_next[LED_RED] = 1'b1;
      end else if (command_bits == green_code) begin
        led_levels_next[LED_GREEN] = 1'b1;
      end else if (command_bits == blue_code) begin
        led_levels_next[LED_BLUE] = 1'b1;
      end else if (command_bits == off_code) begin
        led_levels_next = '0;
      end
      interval_index_next = '0;
      tick_count_next     = '0;
      armed_next          = 1'b0;
      done_next           = 1'b1;
    end else begin
      tick_count_next = elapsed;
    end
  end

  // decode state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      tick_count     <= '0;
      interval_index <= '0;
      command_bits   <= '1;
      decoded_byte   <= '0;
      led_levels     <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (move) begin
        armed          <= armed_next;
        tick_count     <= tick_count_next;
        interval_index <= interval_index_next;
        command_bits   <= command_bits_next;
        decoded_byte   <= decoded_byte_next;
        led_levels     <= led_levels_next;
        res_valid      <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (move) begin
      res.led  <= led_levels_next;
      res.cmd  <= decoded_byte_next;
      res.done <= done_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.led_red      = res.led[LED_RED];
  assign result.led_green    = res.led[LED_GREEN];
  assign result.led_blue     = res.led[LED_BLUE];
  assign result.command_byte = res.cmd;
  assign result.frame_done   = res.done;

`ifndef SYNTH
  // disarming only happens on a frame end that is pushed as a result
  a_disarm_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(armed)) |-> (res_valid && res.done))
    else $error("disarm without frame_done result");

  // idle block holds a cleared counter and index
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !armed |-> (tick_count == '0 && interval_index == '0))
    else $error("counter or index nonzero while disarmed");

  // a frame end reports the command bits held before it
  a_done_byte: assert property (@(posedge clk) disable iff (rst)
    (move && done_next) |=> (res.cmd == $past(command_bits)))
    else $error("decoded byte differs from command bits");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ipdc_pkg::*;

  localparam int TICK_BITS      = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TOTAL_ITEMS    = 1450;
  localparam logic [CFG_W-1:0] CFG_MAX = '1;

  typedef struct packed {
    logic             led_red;
    logic             led_green;
    logic             led_blue;
    logic [CMD_W-1:0] command_byte;
    logic             frame_done;
  } led_outputs_t;

  // decoder state mirror, predicted outputs and mismatch bookkeeping
  class ir_decode_scoreboard;
    logic [CFG_W-1:0]     zero_min    = ZERO_MIN_RST;
    logic [CFG_W-1:0]     zero_max    = ZERO_MAX_RST;
    logic [CFG_W-1:0]     timeout     = TIMEOUT_RST;
    logic [INDEX_W-1:0]   first_cmd   = FIRST_CMD_RST;
    logic [CMD_W-1:0]     red_code    = RED_CODE_RST;
    logic [CMD_W-1:0]     green_code  = GREEN_CODE_RST;
    logic [CMD_W-1:0]     blue_code   = BLUE_CODE_RST;
    logic [CMD_W-1:0]     off_code    = OFF_CODE_RST;

    bit                   armed          = 1'b0;
    logic [TICK_BITS-1:0] tick_count     = '0;
    logic [INDEX_W-1:0]   interval_index = '0;
    logic [CMD_W-1:0]     command_bits   = '1;
    logic [CMD_W-1:0]     decoded_byte   = '0;
    logic [LED_W-1:0]     led_levels     = '0;

    led_outputs_t         predicted_outputs[$];
    int                   errors = 0;

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_ZERO_MIN:   zero_min   = value[CFG_W-1:0];
        REG_ZERO_MAX:   zero_max   = value[CFG_W-1:0];
        REG_TIMEOUT:    timeout    = value[CFG_W-1:0];
        REG_FIRST_CMD:  first_cmd  = value[INDEX_W-1:0];
        REG_RED_CODE:   red_code   = value[CMD_W-1:0];
        REG_GREEN_CODE: green_code = value[CMD_W-1:0];
        REG_BLUE_CODE:  blue_code  = value[CMD_W-1:0];
        REG_OFF_CODE:   off_code   = value[CMD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(logic [2:0] idx);
      case (idx)
        REG_ZERO_MIN:   return 32'(zero_min);
        REG_ZERO_MAX:   return 32'(zero_max);
        REG_TIMEOUT:    return 32'(timeout);
        REG_FIRST_CMD:  return 32'(first_cmd);
        REG_RED_CODE:   return 32'(red_code);
        REG_GREEN_CODE: return 32'(green_code);
        REG_BLUE_CODE:  return 32'(blue_code);
        REG_OFF_CODE:   return 32'(off_code);
        default:        return '0;
      endcase
    endfunction

    // first matching code wins, unknown codes leave the leds alone
    function void apply_command(logic [CMD_W-1:0] code);
      if (code == red_code) led_levels[LED_RED] = 1'b1;
      else if (code == green_code) led_levels[LED_GREEN] = 1'b1;
      else if (code == blue_code) led_levels[LED_BLUE] = 1'b1;
      else if (code == off_code) led_levels = '0;
    endfunction

    // one tick request in, one predicted result out
    function void decode_tick(bit falling);
      logic [TICK_BITS-1:0] elapsed;
      logic [INDEX_W-1:0]   slot;
      led_outputs_t         outs;
      outs.frame_done = 1'b0;
      if (!armed) begin
        if (falling) begin
          armed = 1'b1;
          tick_count = '0;
        end
      end else begin
        elapsed = (tick_count == '1) ? tick_count : tick_count + 1'b1;
        if (falling) begin
          // interval inside the zero window clears the command bit
          if (interval_index >= first_cmd) begin
            slot = interval_index - first_cmd;
            if (slot < CMD_W)
              command_bits[slot[2:0]] = !(elapsed >= zero_min && elapsed <= zero_max);
          end
          if (interval_index != INDEX_MAX) interval_index = interval_index + 1'b1;
          tick_count = '0;
        end else if (elapsed >= timeout) begin
          decoded_byte = command_bits;
          apply_command(decoded_byte);
          interval_index = '0;
          tick_count = '0;
          armed = 1'b0;
          outs.frame_done = 1'b1;
        end else begin
          tick_count = elapsed;
        end
      end
      outs.led_red      = led_levels[LED_RED];
      outs.led_green    = led_levels[LED_GREEN];
      outs.led_blue     = led_levels[LED_BLUE];
      outs.command_byte = decoded_byte;
      predicted_outputs.push_back(outs);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    task check_outputs(led_outputs_t seen);
      led_outputs_t want;
      if (predicted_outputs.size() == 0) begin
        report("result with no tick request pending");
        return;
      end
      want = predicted_outputs.pop_front();
      if (seen.led_red !== want.led_red)
        report($sformatf("led_red got %b want %b", seen.led_red, want.led_red));
      if (seen.led_green !== want.led_green)
        report($sformatf("led_green got %b want %b", seen.led_green, want.led_green));
      if (seen.led_blue !== want.led_blue)
        report($sformatf("led_blue got %b want %b", seen.led_blue, want.led_blue));
      if (seen.command_byte !== want.command_byte)
        report($sformatf("command_byte got %h want %h", seen.command_byte, want.command_byte));
      if (seen.frame_done !== want.frame_done)
        report($sformatf("frame_done got %b want %b", seen.frame_done, want.frame_done));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ipdc_tick_if   tick_if ();
  ipdc_result_if res_if ();

  ir_pulse_distance_command_decoder_unit #(
    .TICK_BITS (TICK_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ir_decode_scoreboard sb = new;
  bit                  edge_plan[$];
  int                  sent_items  = 0;
  int                  burst_left  = 0;
  int                  idle_cycles = 0;
  led_outputs_t        seen;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // apb transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 2'b00};
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // register write with read-back
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    sb.set_register(idx, value);
    apb_access(1'b0, idx, '0, rd);
    if (rd !== sb.register_value(idx))
      sb.report($sformatf("register %0d read %h want %h", idx, rd, sb.register_value(idx)));
  endtask

  task automatic write_window(logic [CFG_W-1:0] zmin, logic [CFG_W-1:0] zmax,
                              logic [CFG_W-1:0] limit, logic [INDEX_W-1:0] first);
    write_reg(REG_ZERO_MIN, 32'(zmin));
    write_reg(REG_ZERO_MAX, 32'(zmax));
    write_reg(REG_TIMEOUT, 32'(limit));
    write_reg(REG_FIRST_CMD, 32'(first));
  endtask

  task automatic write_codes(logic [CMD_W-1:0] r, logic [CMD_W-1:0] g,
                             logic [CMD_W-1:0] b, logic [CMD_W-1:0] o);
    write_reg(REG_RED_CODE, 32'(r));
    write_reg(REG_GREEN_CODE, 32'(g));
    write_reg(REG_BLUE_CODE, 32'(b));
    write_reg(REG_OFF_CODE, 32'(o));
  endtask

  // tick planning
  function automatic void push_interval(int d);
    repeat (d - 1) edge_plan.push_back(1'b0);
    edge_plan.push_back(1'b1);
  endfunction

  function automatic void push_quiet();
    repeat ((sb.timeout == 0) ? 1 : int'(sb.timeout)) edge_plan.push_back(1'b0);
  endfunction

  function automatic void push_noise(int n);
    repeat (n) edge_plan.push_back($urandom_range(0, 3) == 0);
  endfunction

  function automatic int pick_interval(bit want_zero, int cap);
    int d;
    int tries;
    d = 1;
    for (tries = 0; tries < 40; tries++) begin
      d = $urandom_range(1, cap);
      if (((d >= sb.zero_min) && (d <= sb.zero_max)) == want_zero) return d;
    end
    return d;
  endfunction

  function automatic logic [CMD_W-1:0] pick_payload();
    case ($urandom_range(0, 5))
      0: return sb.red_code;
      1: return sb.green_code;
      2: return sb.blue_code;
      3: return sb.off_code;
      default: return CMD_W'($urandom_range(0, 255));
    endcase
  endfunction

  // arming edge, short leader intervals, data intervals, extras, then silence to timeout
  function automatic void build_frame(logic [CMD_W-1:0] payload, int data_bits, int extra);
    int cap;
    int i;
    cap = (sb.timeout == 0) ? 1 : ((sb.timeout > 40) ? 40 : int'(sb.timeout));
    edge_plan.push_back(1'b1);
    for (i = 0; i < sb.first_cmd; i++) push_interval($urandom_range(1, (cap > 2) ? 2 : cap));
    for (i = 0; i < data_bits; i++) push_interval(pick_interval(!payload[i], cap));
    for (i = 0; i < extra; i++) push_interval($urandom_range(1, cap));
    push_quiet();
    repeat ($urandom_range(0, 3)) edge_plan.push_back(1'b0);
  endfunction

  // tick requests in bursts with random gaps
  task automatic send_plan();
    while (edge_plan.size() != 0) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(0, 10)) begin
          @(negedge clk);
          tick_if.valid = 1'b0;
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
      end
      @(negedge clk);
      tick_if.valid = 1'b1;
      tick_if.falling_edge = edge_plan.pop_front();
      do @(posedge clk); while (!tick_if.ready);
      burst_left--;
      sent_items++;
    end
    @(negedge clk);
    tick_if.valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.predicted_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic randomize_settings();
    logic [CFG_W-1:0]   lo;
    logic [CFG_W-1:0]   hi;
    logic [CFG_W-1:0]   limit;
    logic [INDEX_W-1:0] first;
    logic [CMD_W-1:0]   r;
    lo = CFG_W'($urandom_range(1, 6));
    hi = lo + CFG_W'($urandom_range(0, 6));
    limit = hi + CFG_W'($urandom_range(1, 8));
    if ($urandom_range(0, 9) == 0) limit = CFG_W'($urandom_range(0, 3));
    // occasionally an empty zero window
    if ($urandom_range(0, 7) == 0) {lo, hi} = {hi + 20'd1, lo};
    first = INDEX_W'(($urandom_range(0, 11) == 0) ? $urandom_range(100, 127)
                                                  : $urandom_range(0, 8));
    write_window(lo, hi, limit, first);
    if ($urandom_range(0, 1) == 1) begin
      r = CMD_W'($urandom_range(0, 255));
      write_codes(r, ($urandom_range(0, 3) == 0) ? r : CMD_W'($urandom_range(0, 255)),
                  CMD_W'($urandom_range(0, 255)), CMD_W'($urandom_range(0, 255)));
    end
  endtask

  // result stall pattern: free-running, random, then stall runs
  initial begin : result_stall
    int stall_left;
    int rx_cycle;
    stall_left = 0;
    rx_cycle = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      case ((rx_cycle / 256) % 3)
        0: res_if.ready = 1'b1;
        1: res_if.ready = ($urandom_range(0, 9) < 7);
        default: begin
          if (stall_left > 0) begin
            res_if.ready = 1'b0;
            stall_left--;
          end else begin
            res_if.ready = 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
          end
        end
      endcase
    end
  end

  // accepted tick and result requests, plus the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (tick_if.valid && tick_if.ready) sb.decode_tick(tick_if.falling_edge);
      if (res_if.valid && res_if.ready) begin
        seen.led_red      = res_if.led_red;
        seen.led_green    = res_if.led_green;
        seen.led_blue     = res_if.led_blue;
        seen.command_byte = res_if.command_byte;
        seen.frame_done   = res_if.frame_done;
        sb.check_outputs(seen);
      end
      if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ir_pulse_distance_command_decoder_unit regression: fail");
        $finish;
      end
    end
  end

  // main sequence
  initial begin : stimulus
    logic [31:0] rd;
    int          i;
    int          sat_slots[2];
    sat_slots = '{120, 127};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_if.valid = 1'b0;
    tick_if.falling_edge = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // registers come out of reset at their defaults
    for (i = 0; i < 8; i++) begin
      apb_access(1'b0, i[2:0], '0, rd);
      if (rd !== sb.register_value(i[2:0]))
        sb.report($sformatf("reset value of register %0d read %h", i, rd));
    end

    // a few ticks under the long reset timeout leave the block armed
    push_noise(16);
    send_plan();
    drain();

    // every led code, a short frame, extras and an edge right at timeout
    write_window(20'd1, 20'd2, 20'd4, 7'd0);
    build_frame(sb.red_code, 8, 0);
    build_frame(sb.green_code, 8, 0);
    build_frame(sb.blue_code, 8, 0);
    build_frame(sb.off_code, 8, 0);
    build_frame(8'hA5, 3, 0);
    build_frame(8'h5A, 8, 3);
    send_plan();
    drain();

    // full zero window, single-tick timeout, overlapping codes at the byte extremes
    write_codes(8'd0, 8'd0, 8'd255, 8'd128);
    write_window(20'd0, CFG_MAX, 20'd1, 7'd0);
    build_frame(8'h00, 8, 0);
    build_frame(8'hFF, 8, 1);
    push_noise(12);
    push_quiet();
    send_plan();
    drain();

    // empty window with zero timeout and the last legal first slot
    write_window(CFG_MAX, 20'd3, 20'd0, 7'd119);
    build_frame(8'hFF, 8, 0);
    build_frame(8'h00, 4, 0);
    send_plan();
    drain();

    // interval index saturating at the top of its range
    for (i = 0; i < 2; i++) begin
      write_window(20'd2, 20'd3, 20'd6, sat_slots[i][INDEX_W-1:0]);
      build_frame(pick_payload(), 8, 12);
      send_plan();
      drain();
    end

    // largest timeout: the frame stays open through this phase
    write_window(20'd2, 20'd3, CFG_MAX, 7'd4);
    push_noise(30);
    send_plan();
    drain();

    // random settings, mostly well-formed frames, some short frames and noise
    while (sent_items < TOTAL_ITEMS) begin
      randomize_settings();
      repeat ($urandom_range(3, 6)) begin
        if (sent_items + edge_plan.size() < TOTAL_ITEMS) begin
          i = $urandom_range(0, 19);
          if (i < 14) build_frame(pick_payload(), 8, ($urandom_range(0, 3) == 0) ? 2 : 0);
          else if (i < 17) build_frame(pick_payload(), $urandom_range(0, 7), 0);
          else begin
            push_noise($urandom_range(4, 30));
            push_quiet();
          end
        end
      end
      send_plan();
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.predicted_outputs.size() != 0) sb.report("results still outstanding at end");
    if (sb.errors == 0) begin
      $display("ir_pulse_distance_command_decoder_unit regression: pass");
    end else begin
      $display("ir_pulse_distance_command_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ipdc_pkg.sv
rtl/ipdc_tick_if.sv
rtl/ipdc_result_if.sv
rtl/ir_pulse_distance_command_decoder_unit.sv
tb/tb_top.sv
